>>> rtl/core/brle_pkg.sv
// brle_pkg: beat types, queue sizing and run cap for the byte run-length encoder.
// No dependencies; imported by every module of the encoder.
package brle_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;
	localparam int unsigned QCW    = 3;

	localparam logic [7:0] RUN_CAP = 8'd255;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_block;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] run_byte;
		logic [7:0] run_length;
		logic       final_pair;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_beat_t  first;
		out_beat_t  second;
	} push_t;

endpackage

>>> rtl/core/brle_front.sv
// brle_front: accepts input beats, tracks the open run and classifies each byte.
// Pushes zero, one or two pairs per beat into the queue. Depends on brle_pkg.
module brle_front import brle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     data_valid,
	output logic     data_ready,
	input  in_beat_t data,
	input  logic     space,
	output push_t    push
);

	logic [7:0] open_byte_q;
	logic [7:0] open_count_q;
	logic       run_open_q;

	logic       accept;
	logic       extend;
	logic       close;
	logic [7:0] next_byte;
	logic [7:0] next_count;
	out_beat_t  closed_pair;
	out_beat_t  last_pair;

	assign data_ready = space;
	assign accept     = data_valid && space;

	assign extend = run_open_q && (data.data_byte == open_byte_q) && (open_count_q != RUN_CAP);
	assign close  = run_open_q && !extend;

	assign next_byte  = extend ? open_byte_q : data.data_byte;
	assign next_count = extend ? open_count_q + 8'd1 : 8'd1;

	assign closed_pair = '{run_byte: open_byte_q, run_length: open_count_q, final_pair: 1'b0};
	assign last_pair   = '{run_byte: next_byte, run_length: next_count, final_pair: 1'b1};

	always_comb begin
		push.cnt    = 2'd0;
		push.first  = close ? closed_pair : last_pair;
		push.second = last_pair;
		if (accept) begin
			push.cnt = {1'b0, close} + {1'b0, data.end_of_block};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_byte_q  <= '0;
			open_count_q <= '0;
			run_open_q   <= 1'b0;
		end else if (accept) begin
			open_byte_q <= next_byte;
			if (data.end_of_block) begin
				open_count_q <= '0;
				run_open_q   <= 1'b0;
			end else begin
				open_count_q <= next_count;
				run_open_q   <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/brle_queue.sv
// brle_queue: short pair queue with a two-entry write port and a one-entry read port.
// Decouples the classifier from the output stage. Depends on brle_pkg.
module brle_queue import brle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      space,
	output logic      avail,
	output out_beat_t head,
	input  logic      pop
);

	out_beat_t          mem_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QCW-1:0]     count_q;
	logic [QAW-1:0]     wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + QAW'(1);
	assign space     = count_q <= QCW'(QDEPTH - 2);
	assign avail     = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push.cnt) - QCW'(pop);
		end
	end

endmodule

>>> rtl/core/brle_back.sv
// brle_back: output register that drains the pair queue onto the result channel.
// Depends on brle_pkg.
module brle_back import brle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      avail,
	input  out_beat_t head,
	output logic      pop,
	output logic      pair_valid,
	input  logic      pair_ready,
	output out_beat_t pair
);

	logic      valid_q;
	out_beat_t pair_q;

	assign pop        = avail && (!valid_q || pair_ready);
	assign pair_valid = valid_q;
	assign pair       = pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (pair_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pair_q <= head;
		end
	end

endmodule

>>> rtl/core/byte_rle_encoder.sv
// byte_rle_encoder: top level of the streaming byte run-length encoder.
// Instantiates brle_front, brle_queue and brle_back; depends on brle_pkg.
//
//  channel | valid      | ready      | beat                                  | dir
//  data    | data_valid | data_ready | data_byte, end_of_block              | in
//  pair    | pair_valid | pair_ready | run_byte, run_length, final_pair     | out
//
// One data beat per cycle while the queue has room for two pairs.
// With an idle output a pair passes through the queue and then the output register before
// it shows on pair; the output drains one pair per cycle while pair_ready is high, so a
// stream where every byte closes a run runs at one beat per cycle.
// Reset clears the open run, queue pointers and output valid; no clearing pass.
// A stalled pair side backs pairs up in the four-entry queue; data_ready drops while
// more than two pairs wait there.
module byte_rle_encoder import brle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      data_valid,
	output logic      data_ready,
	input  in_beat_t  data,
	output logic      pair_valid,
	input  logic      pair_ready,
	output out_beat_t pair
);

	push_t     push;
	logic      space;
	logic      avail;
	logic      pop;
	out_beat_t head;

	brle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data       (data),
		.space      (space),
		.push       (push)
	);

	brle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.space  (space),
		.avail  (avail),
		.head   (head),
		.pop    (pop)
	);

	brle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (avail),
		.head       (head),
		.pop        (pop),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair)
	);

endmodule

>>> rtl/core/brle_checker.sv
// brle_checker: port-level assertions for byte_rle_encoder, attached by bind.
// Depends on brle_pkg.
module brle_checker import brle_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      data_valid,
	input logic      data_ready,
	input in_beat_t  data,
	input logic      pair_valid,
	input logic      pair_ready,
	input out_beat_t pair
);

	a_pair_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_ready |=> pair_valid)
		else $error("pair beat dropped while stalled");

	a_pair_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_ready |=> $stable(pair))
		else $error("pair beat changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid |-> pair.run_length != 8'd0)
		else $error("pair with zero run length");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_ready && data.end_of_block |-> ##2 pair_valid)
		else $error("end of block produced no pair");

endmodule

bind byte_rle_encoder brle_checker u_brle_checker (.*);

>>> tb/tb_top.sv
// tb_top: self-checking bench for byte_rle_encoder, built from brle_pkg and the encoder RTL.
// Drives directed and random byte blocks with random idling on both sides and predicts
// every (byte, count) pair in order, comparing each output beat field by field.
module tb_top;
	import brle_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      data_valid = 1'b0;
	logic      data_ready;
	in_beat_t  data = '0;
	logic      pair_valid;
	logic      pair_ready = 1'b0;
	out_beat_t pair;

	in_beat_t  raw_stream[$];
	out_beat_t pairs_due[$];

	logic [7:0]  held_byte = 8'd0;
	logic [7:0]  held_count = 8'd0;
	logic        run_live = 1'b0;

	logic        live = 1'b0;
	logic        data_taken = 1'b0;
	logic        pair_taken = 1'b0;
	int unsigned in_gap = 0;
	int unsigned out_stall = 0;
	bit          in_idle_on = 1'b1;
	bit          out_idle_on = 1'b1;

	int unsigned mismatches = 0;
	int unsigned beats_in = 0;
	int unsigned blocks_in = 0;
	int unsigned pairs_out = 0;
	int unsigned capped_runs = 0;

	byte_rle_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data       (data),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap(bit idle_on);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int unsigned pick_run_len();
		int unsigned r;
		r = $urandom_range(0, 199);
		if (r < 2)
			return $urandom_range(250, 260);
		if (r < 130)
			return $urandom_range(1, 3);
		if (r < 180)
			return $urandom_range(4, 20);
		return $urandom_range(21, 80);
	endfunction

	task automatic push_beat(logic [7:0] b, logic eob);
		in_beat_t beat;
		beat.data_byte    = b;
		beat.end_of_block = eob;
		raw_stream = {raw_stream, beat};
	endtask

	task automatic push_run(logic [7:0] b, int unsigned len, logic eob);
		for (int unsigned i = 0; i < len; i++)
			push_beat(b, eob && (i == len - 1));
	endtask

	task automatic push_block();
		int unsigned runs;
		runs = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		for (int unsigned i = 0; i < runs; i++)
			push_run(pick_byte(), pick_run_len(), i == runs - 1);
	endtask

	task automatic build_stimulus();
		int unsigned target;
		int unsigned n;
		push_beat(8'h00, 1'b1);
		push_beat(8'hFF, 1'b1);
		push_run(8'h11, 2, 1'b0);
		push_beat(8'h22, 1'b1);
		push_run(8'hA5, 4, 1'b0);
		push_run(8'h3C, 2, 1'b1);
		for (int i = 0; i < 8; i++)
			push_beat(8'h01 << i, i == 7);
		push_run(8'h7E, 2, 1'b1);
		push_beat(8'h7E, 1'b1);

		target = raw_stream.size() + 1700;
		push_run(8'h5A, 255, 1'b1);
		push_run(8'hC3, 256, 1'b1);
		while (raw_stream.size() < target) begin
			if ($urandom_range(0, 99) < 85) begin
				push_block();
			end else begin
				n = $urandom_range(1, 12);
				for (int unsigned i = 0; i < n; i++)
					push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			end
		end
		push_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic emit_pair(logic [7:0] b, logic [7:0] len, logic fin);
		out_beat_t p;
		p.run_byte   = b;
		p.run_length = len;
		p.final_pair = fin;
		pairs_due = {pairs_due, p};
		if (len == RUN_CAP)
			capped_runs++;
	endtask

	task automatic encode_byte(in_beat_t beat);
		if (run_live && beat.data_byte == held_byte && held_count != RUN_CAP) begin
			held_count = held_count + 8'd1;
		end else begin
			if (run_live)
				emit_pair(held_byte, held_count, 1'b0);
			held_byte  = beat.data_byte;
			held_count = 8'd1;
			run_live   = 1'b1;
		end
		if (beat.end_of_block) begin
			emit_pair(held_byte, held_count, 1'b1);
			held_count = 8'd0;
			run_live   = 1'b0;
			blocks_in++;
		end
		beats_in++;
	endtask

	task automatic check_pair(out_beat_t got);
		out_beat_t want;
		pairs_out++;
		if (pairs_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected pair: byte=%02h len=%0d final=%0b",
					got.run_byte, got.run_length, got.final_pair);
		end else begin
			want = pairs_due.pop_front();
			if (got.run_byte !== want.run_byte || got.run_length !== want.run_length ||
					got.final_pair !== want.final_pair) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"pair %0d: expected byte=%02h len=%0d final=%0b, ",
						"got byte=%02h len=%0d final=%0b"},
						pairs_out, want.run_byte, want.run_length, want.final_pair,
						got.run_byte, got.run_length, got.final_pair);
			end
		end
	endtask

	always @(posedge clk) begin
		live       <= arst_n;
		data_taken <= arst_n && data_valid && data_ready;
		pair_taken <= arst_n && pair_valid && pair_ready;
		if (arst_n) begin
			if (pair_valid && pair_ready)
				check_pair(pair);
			if (data_valid && data_ready)
				encode_byte(data);
		end
	end

	always @(negedge clk) begin
		if (!live) begin
			data_valid <= 1'b0;
		end else if (!data_valid || data_taken) begin
			if (data_taken) begin
				if ($urandom_range(0, 249) == 0)
					in_idle_on = !in_idle_on;
				in_gap = pick_gap(in_idle_on);
			end
			if (in_gap != 0) begin
				in_gap--;
				data_valid <= 1'b0;
			end else if (raw_stream.size() != 0) begin
				data       <= raw_stream.pop_front();
				data_valid <= 1'b1;
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (pair_taken) begin
			if ($urandom_range(0, 249) == 0)
				out_idle_on = !out_idle_on;
			out_stall = pick_gap(out_idle_on);
		end
		if (out_stall != 0) begin
			out_stall--;
			pair_ready <= 1'b0;
		end else begin
			pair_ready <= 1'b1;
		end
	end

	initial begin
		build_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (raw_stream.size() != 0 || data_valid)
			@(posedge clk);
		while (pairs_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("run covered %0d data beats in %0d blocks",
			beats_in, blocks_in);
		$display("%0d pairs checked, %0d of them capped at 255",
			pairs_out, capped_runs);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d pairs still due", pairs_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule
